@@ hdl/x86alu_pkg.sv @@
`default_nettype none

package x86alu_pkg;

  typedef enum logic [4:0] {
    KIND_ADD  = 5'd0,
    KIND_ADC  = 5'd1,
    KIND_SUB  = 5'd2,
    KIND_SBB  = 5'd3,
    KIND_CMP  = 5'd4,
    KIND_AND  = 5'd5,
    KIND_OR   = 5'd6,
    KIND_XOR  = 5'd7,
    KIND_TEST = 5'd8,
    KIND_INC  = 5'd9,
    KIND_DEC  = 5'd10,
    KIND_NEG  = 5'd11,
    KIND_NOT  = 5'd12,
    KIND_SHL  = 5'd13,
    KIND_SHR  = 5'd14,
    KIND_SAR  = 5'd15,
    KIND_ROL  = 5'd16,
    KIND_ROR  = 5'd17,
    KIND_RCL  = 5'd18,
    KIND_RCR  = 5'd19
  } kind_e;

  localparam logic [15:0] MASK_BYTE = 16'h00FF;
  localparam logic [15:0] MASK_WORD = 16'hFFFF;
  localparam logic [15:0] SIGN_BYTE = 16'h0080;
  localparam logic [15:0] SIGN_WORD = 16'h8000;

  typedef struct packed {
    logic of;
    logic sf;
    logic zf;
    logic af;
    logic pf;
    logic cf;
  } flags_t;

  typedef struct packed {
    logic [15:0] result;
    logic        writes_back;
    flags_t      flags;
  } res_t;

  // Top bit of a value at the operation size.
  function automatic logic size_msb(input logic [15:0] x, input logic word);
    size_msb = word ? x[15] : x[7];
  endfunction

endpackage

`default_nettype wire

@@ hdl/x86alu_in_if.sv @@
`default_nettype none

interface x86alu_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic        word_size;
  logic [15:0] operand_a;
  logic [15:0] operand_b;

  modport source (
    output valid, kind, word_size, operand_a, operand_b,
    input  ready
  );

  modport sink (
    input  valid, kind, word_size, operand_a, operand_b,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/x86alu_out_if.sv @@
`default_nettype none

interface x86alu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result;
  logic        writes_back;
  logic        carry_out;
  logic        parity_out;
  logic        aux_carry_out;
  logic        zero_out;
  logic        sign_out;
  logic        overflow_out;

  modport source (
    output valid, result, writes_back, carry_out, parity_out, aux_carry_out,
           zero_out, sign_out, overflow_out,
    input  ready
  );

  modport sink (
    input  valid, result, writes_back, carry_out, parity_out, aux_carry_out,
           zero_out, sign_out, overflow_out,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/x86_alu_with_flags.sv @@
`default_nettype none

// Byte/word 8086-style ALU with a six-bit flag register. One operation is
// accepted per clock cycle unless the output stalls; its result and flags
// reach the output through two register stages, input and result. The
// throughput of one item per cycle is set by the flag register, which is
// read by the single combinational pass between the two stages and
// rewritten at the edge where that item moves into the result register, so
// that the next item always sees the flags left by the one before it. While
// a finished result waits to be taken, the input side can still take one item
// if the input register is empty, and after that it stalls until the result
// transfer happens.
module x86_alu_with_flags import x86alu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  x86alu_in_if.sink    in_i,
  x86alu_out_if.source out_o
);

  logic        in_vld_q;
  logic [4:0]  kind_q;
  logic        word_size_q;
  logic [15:0] operand_a_q;
  logic [15:0] operand_b_q;
  logic        out_vld_q;
  logic        out_vld_d;
  res_t        out_q;
  res_t        exec_res;
  flags_t      flags_q;
  logic        advance;
  logic        in_ready;

  assign advance  = in_vld_q & (~out_vld_q | out_o.ready);
  assign in_ready = ~in_vld_q | advance;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      kind_q      <= in_i.kind;
      word_size_q <= in_i.word_size;
      operand_a_q <= in_i.operand_a;
      operand_b_q <= in_i.operand_b;
    end
  end

  x86alu_exec u_exec (
    .kind_i      (kind_q),
    .word_size_i (word_size_q),
    .operand_a_i (operand_a_q),
    .operand_b_i (operand_b_q),
    .flags_i     (flags_q),
    .res_o       (exec_res)
  );

  assign out_vld_d = advance | (out_vld_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      flags_q   <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      if (advance) begin
        flags_q <= exec_res.flags;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= exec_res;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.result        = out_q.result;
  assign out_o.writes_back   = out_q.writes_back;
  assign out_o.carry_out     = out_q.flags.cf;
  assign out_o.parity_out    = out_q.flags.pf;
  assign out_o.aux_carry_out = out_q.flags.af;
  assign out_o.zero_out      = out_q.flags.zf;
  assign out_o.sign_out      = out_q.flags.sf;
  assign out_o.overflow_out  = out_q.flags.of;

  // The flags shown with a waiting result are always the live flag state.
  a_flags_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.flags == flags_q))
    else $error("output flags differ from flag register");

  a_flags_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(flags_q))
    else $error("flag register changed without an item completing");

  a_advance_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("completed item did not reach the result register");

  a_cmp_no_wb : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && ((kind_q == KIND_CMP) || (kind_q == KIND_TEST))) |=> !out_q.writes_back)
    else $error("compare or test marked for write-back");

  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> in_ready)
    else $error("empty input stage refused a transfer");

endmodule

`default_nettype wire

@@ hdl/x86alu_exec.sv @@
`default_nettype none

module x86alu_exec import x86alu_pkg::*; (
  input  logic [4:0]  kind_i,
  input  logic        word_size_i,
  input  logic [15:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  input  flags_t      flags_i,
  output res_t        res_o
);

  logic        w;
  logic [15:0] m;
  logic [15:0] t;
  logic [15:0] a;
  logic [15:0] b;
  logic [4:0]  cnt;
  logic        sa;
  logic        sb;
  logic        add_c;
  logic        sub_c;
  logic [16:0] sum17;
  logic [16:0] dif17;
  logic [31:0] shl32;
  logic [31:0] shr32;
  logic [15:0] sx;
  logic [16:0] sar17;
  logic [31:0] rolw32;
  logic [31:0] rorw32;
  logic [15:0] rolb16;
  logic [15:0] rorb16;
  logic [4:0]  kw17;
  logic [4:0]  kb9_full;
  logic [3:0]  kb9;
  logic [16:0] v17;
  logic [8:0]  v9;
  logic [33:0] rclw34;
  logic [33:0] rcrw34;
  logic [17:0] rclb18;
  logic [17:0] rcrb18;
  logic [15:0] r;
  logic        wb;
  logic        szp;
  logic        rot_cf;
  flags_t      f;

  assign w   = word_size_i;
  assign m   = w ? MASK_WORD : MASK_BYTE;
  assign t   = w ? SIGN_WORD : SIGN_BYTE;
  assign a   = operand_a_i & m;
  assign b   = operand_b_i & m;
  assign cnt = operand_b_i[4:0];
  assign sa  = size_msb(a, w);
  assign sb  = size_msb(b, w);

  assign add_c = (kind_i == KIND_ADC) & flags_i.cf;
  assign sub_c = (kind_i == KIND_SBB) & flags_i.cf;
  assign sum17 = {1'b0, a} + {1'b0, b} + {16'd0, add_c};
  assign dif17 = {1'b0, a} - {1'b0, b} - {16'd0, sub_c};

  // Zero-extended shifters (sign-extended for SAR): the bit just past the result is the last bit shifted out.
  assign shl32 = {16'd0, a} << cnt;
  assign shr32 = {a, 16'd0} >> cnt;
  assign sx    = w ? a : {{8{a[7]}}, a[7:0]};
  assign sar17 = $signed({sx, 1'b0}) >>> cnt;

  assign rolw32 = {a, a} << cnt[3:0];
  assign rorw32 = {a, a} >> cnt[3:0];
  assign rolb16 = {a[7:0], a[7:0]} << cnt[2:0];
  assign rorb16 = {a[7:0], a[7:0]} >> cnt[2:0];

  // Rotates through carry turn over seventeen or nine bit positions.
  assign kw17 = (cnt >= 5'd17) ? cnt - 5'd17 : cnt;
  always_comb begin
    if (cnt >= 5'd27) begin
      kb9_full = cnt - 5'd27;
    end else if (cnt >= 5'd18) begin
      kb9_full = cnt - 5'd18;
    end else if (cnt >= 5'd9) begin
      kb9_full = cnt - 5'd9;
    end else begin
      kb9_full = cnt;
    end
  end
  assign kb9    = kb9_full[3:0];
  assign v17    = {flags_i.cf, a};
  assign v9     = {flags_i.cf, a[7:0]};
  assign rclw34 = {v17, v17} << kw17;
  assign rcrw34 = {v17, v17} >> kw17;
  assign rclb18 = {v9, v9} << kb9;
  assign rcrb18 = {v9, v9} >> kb9;

  always_comb begin
    r      = a;
    wb     = 1'b1;
    szp    = 1'b1;
    rot_cf = flags_i.cf;
    f      = flags_i;
    case (kind_e'(kind_i))
      KIND_ADD, KIND_ADC: begin
        r    = sum17[15:0] & m;
        f.cf = w ? sum17[16] : sum17[8];
        f.af = a[4] ^ b[4] ^ r[4];
        f.of = ~(sa ^ sb) & (size_msb(r, w) ^ sa);
      end
      KIND_SUB, KIND_SBB, KIND_CMP: begin
        r    = dif17[15:0] & m;
        f.cf = dif17[16];
        f.af = a[4] ^ b[4] ^ r[4];
        f.of = (sa ^ sb) & (size_msb(r, w) ^ sa);
        wb   = (kind_i != KIND_CMP);
      end
      KIND_AND, KIND_OR, KIND_XOR, KIND_TEST: begin
        if (kind_i == KIND_OR) begin
          r = a | b;
        end else if (kind_i == KIND_XOR) begin
          r = a ^ b;
        end else begin
          r = a & b;
        end
        f.cf = 1'b0;
        f.af = 1'b0;
        f.of = 1'b0;
        wb   = (kind_i != KIND_TEST);
      end
      KIND_INC: begin
        r    = (a + 16'd1) & m;
        f.af = (r[3:0] == 4'h0);
        f.of = (r == t);
      end
      KIND_DEC: begin
        r    = (a - 16'd1) & m;
        f.af = (r[3:0] == 4'hF);
        f.of = (r == t - 16'd1);
      end
      KIND_NEG: begin
        r    = (16'd0 - b) & m;
        f.of = (b == t);
        f.af = (r[3:0] != 4'h0);
        f.cf = (b != 16'd0);
      end
      KIND_NOT: begin
        r   = ~b & m;
        szp = 1'b0;
      end
      KIND_SHL: begin
        r    = shl32[15:0] & m;
        f.af = (cnt != 5'd0);
        if (cnt != 5'd0) begin
          f.cf = w ? shl32[16] : shl32[8];
        end
        f.of = sa ^ size_msb(r, w);
      end
      KIND_SHR: begin
        r    = shr32[31:16];
        f.af = (cnt != 5'd0);
        if (cnt != 5'd0) begin
          f.cf = shr32[15];
        end
        f.of = (cnt == 5'd1) & sa;
      end
      KIND_SAR: begin
        r    = sar17[16:1] & m;
        f.af = (cnt != 5'd0);
        if (cnt != 5'd0) begin
          f.cf = sar17[0];
        end
        f.of = 1'b0;
      end
      KIND_ROL: begin
        r = w ? rolw32[31:16] : {8'd0, rolb16[15:8]};
        if (cnt != 5'd0) begin
          rot_cf = r[0];
        end
        f.cf = rot_cf;
        f.of = rot_cf ^ size_msb(r, w);
        szp  = 1'b0;
      end
      KIND_ROR: begin
        r = w ? rorw32[15:0] : {8'd0, rorb16[7:0]};
        if (cnt != 5'd0) begin
          rot_cf = size_msb(r, w);
        end
        f.cf = rot_cf;
        f.of = w ? (r[15] ^ r[14]) : (r[7] ^ r[6]);
        szp  = 1'b0;
      end
      KIND_RCL: begin
        r      = w ? rclw34[32:17] : {8'd0, rclb18[16:9]};
        rot_cf = w ? rclw34[33] : rclb18[17];
        f.cf   = rot_cf;
        f.of   = rot_cf ^ size_msb(r, w);
        szp    = 1'b0;
      end
      KIND_RCR: begin
        r      = w ? rcrw34[15:0] : {8'd0, rcrb18[7:0]};
        rot_cf = w ? rcrw34[16] : rcrb18[8];
        f.cf   = rot_cf;
        f.of   = w ? (r[15] ^ r[14]) : (r[7] ^ r[6]);
        szp    = 1'b0;
      end
      default: begin
        // Unused codes leave the destination and the flags alone.
        r   = a;
        wb  = 1'b0;
        szp = 1'b0;
      end
    endcase
    if (szp) begin
      f.sf = size_msb(r, w);
      f.zf = (r == 16'd0);
      f.pf = ~^r[7:0];
    end
  end

  assign res_o.result      = r;
  assign res_o.writes_back = wb;
  assign res_o.flags       = f;

endmodule

`default_nettype wire

@@ dv/x86_alu_with_flags_tb.sv @@
`default_nettype none

module x86_alu_with_flags_tb;
  import x86alu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [4:0]  kind;
    logic        word;
    logic [15:0] a;
    logic [15:0] b;
  } alu_op_t;

  localparam logic [15:0] CORNERS [8] = '{16'h0000, 16'h0001, 16'h007F, 16'h0080,
                                          16'h00FF, 16'h7FFF, 16'h8000, 16'hFFFF};
  localparam logic [4:0] KIND_UNUSED_LO = 5'd20;
  localparam logic [4:0] KIND_UNUSED_HI = 5'd31;
  localparam int RANDOM_BATCHES = 4;
  localparam int BATCH_OPS      = 163;

  logic clk_i = 1'b0;
  logic rst_ni;

  x86alu_in_if  in_if ();
  x86alu_out_if out_if ();

  x86_alu_with_flags uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #6 clk_i = ~clk_i;

  alu_op_t pending_ops [$];
  res_t    alu_results_due [$];
  flags_t  shadow_flags;
  alu_op_t shown_op;
  int      send_gap;
  int      take_gap;
  int      mismatch_count;
  bit      calm;

  // Executes one operation on the shadow flag register and returns what the
  // block should produce for it.
  function automatic res_t exec_alu_op(input alu_op_t op);
    logic [15:0] m, t, a, b, r;
    logic [31:0] full, v, wide;
    int unsigned n, cnt, k, s;
    logic        cin, wb, szp;
    flags_t      f;
    m    = op.word ? MASK_WORD : MASK_BYTE;
    t    = op.word ? SIGN_WORD : SIGN_BYTE;
    n    = op.word ? 16 : 8;
    a    = op.a & m;
    b    = op.b & m;
    cnt  = op.b[4:0];
    f    = shadow_flags;
    r    = a;
    wb   = 1'b1;
    szp  = 1'b1;
    cin  = f.cf;
    case (op.kind)
      KIND_ADD, KIND_ADC: begin
        if (op.kind == KIND_ADD) cin = 1'b0;
        full = 32'(a) + 32'(b) + 32'(cin);
        r    = full[15:0] & m;
        f.cf = full > 32'(m);
        f.af = ((a ^ b ^ r) & 16'h0010) != 0;
        f.of = ((a ^ b ^ t) & (r ^ a) & t) != 0;
      end
      KIND_SUB, KIND_SBB, KIND_CMP: begin
        if (op.kind != KIND_SBB) cin = 1'b0;
        full = 32'(a) - 32'(b) - 32'(cin);
        r    = full[15:0] & m;
        f.cf = 32'(a) < 32'(b) + 32'(cin);
        f.af = ((a ^ b ^ r) & 16'h0010) != 0;
        f.of = ((a ^ b) & (r ^ a) & t) != 0;
        wb   = op.kind != KIND_CMP;
      end
      KIND_AND, KIND_OR, KIND_XOR, KIND_TEST: begin
        if (op.kind == KIND_OR) r = a | b;
        else if (op.kind == KIND_XOR) r = a ^ b;
        else r = a & b;
        f.cf = 1'b0;
        f.af = 1'b0;
        f.of = 1'b0;
        wb   = op.kind != KIND_TEST;
      end
      KIND_INC: begin
        r    = (a + 16'd1) & m;
        f.af = r[3:0] == 4'h0;
        f.of = r == t;
      end
      KIND_DEC: begin
        r    = (a - 16'd1) & m;
        f.af = r[3:0] == 4'hF;
        f.of = r == t - 16'd1;
      end
      KIND_NEG: begin
        r    = (16'd0 - b) & m;
        f.of = b == t;
        f.af = r[3:0] != 4'h0;
        f.cf = b != 0;
      end
      KIND_NOT: begin
        r   = ~b & m;
        szp = 1'b0;
      end
      KIND_SHL: begin
        f.af = cnt != 0;
        if (cnt != 0) f.cf = (cnt <= n) ? a[n - cnt] : 1'b0;
        r    = (cnt >= n) ? 16'd0 : ((a << cnt) & m);
        f.of = ((a ^ r) & t) != 0;
      end
      KIND_SHR: begin
        f.af = cnt != 0;
        f.of = (cnt == 1) ? ((a & t) != 0) : 1'b0;
        if (cnt != 0) f.cf = (cnt <= n) ? a[cnt - 1] : 1'b0;
        r    = (cnt >= n) ? 16'd0 : (a >> cnt);
      end
      KIND_SAR: begin
        f.af = cnt != 0;
        if (cnt != 0) begin
          s    = (cnt - 1 < n - 1) ? cnt - 1 : n - 1;
          f.cf = a[s];
        end
        k = (cnt < n) ? cnt : n - 1;
        r = a >> k;
        if ((a & t) != 0) r |= m & ~(m >> k);
        f.of = 1'b0;
      end
      KIND_ROL: begin
        k = cnt % n;
        r = (k != 0) ? (((a << k) | (a >> (n - k))) & m) : a;
        if (cnt != 0) f.cf = r[0];
        f.of = f.cf ^ ((r & t) != 0);
        szp  = 1'b0;
      end
      KIND_ROR: begin
        k = cnt % n;
        r = (k != 0) ? (((a >> k) | (a << (n - k))) & m) : a;
        if (cnt != 0) f.cf = (r & t) != 0;
        f.of = r[n - 1] ^ r[n - 2];
        szp  = 1'b0;
      end
      KIND_RCL, KIND_RCR: begin
        // The carry sits just above the operand, making an n+1 bit ring.
        wide = (32'(m) << 1) | 32'd1;
        v    = (32'(cin) << n) | 32'(a);
        k    = cnt % (n + 1);
        if (k != 0) begin
          if (op.kind == KIND_RCL) v = ((v << k) | (v >> (n + 1 - k))) & wide;
          else v = ((v >> k) | (v << (n + 1 - k))) & wide;
        end
        r    = v[15:0] & m;
        f.cf = v[n];
        if (op.kind == KIND_RCL) f.of = f.cf ^ ((r & t) != 0);
        else f.of = r[n - 1] ^ r[n - 2];
        szp  = 1'b0;
      end
      default: begin
        wb  = 1'b0;
        szp = 1'b0;
      end
    endcase
    if (szp) begin
      f.sf = (r & t) != 0;
      f.zf = r == 16'd0;
      f.pf = ~^r[7:0];
    end
    shadow_flags = f;
    return '{result: r & m, writes_back: wb, flags: f};
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t ns: %s expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic queue_op(input logic [4:0] kind, input logic word,
                          input logic [15:0] a, input logic [15:0] b);
    pending_ops.push_back('{kind: kind, word: word, a: a, b: b});
  endtask

  function automatic logic [15:0] pick_operand();
    if ($urandom_range(0, 4) == 0) return CORNERS[$urandom_range(0, 7)];
    return 16'($urandom);
  endfunction

  // Source side: presents queued operations, with random bursts of idle cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.kind      <= '0;
      in_if.word_size <= 1'b0;
      in_if.operand_a <= '0;
      in_if.operand_b <= '0;
      shadow_flags    = '0;
      send_gap        = 0;
    end else begin
      if (in_if.valid && in_if.ready)
        alu_results_due.push_back(exec_alu_op(shown_op));
      if (in_if.valid && !in_if.ready) begin
        // Hold the offered operation until the transfer completes.
      end else if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 10);
        in_if.valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        shown_op = pending_ops.pop_front();
        in_if.kind      <= shown_op.kind;
        in_if.word_size <= shown_op.word;
        in_if.operand_a <= shown_op.a;
        in_if.operand_b <= shown_op.b;
        in_if.valid     <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Sink side: takes results with random stalls and checks each transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      take_gap     = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (alu_results_due.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result expected none, actual %h", $time, out_if.result);
        end else begin
          res_t due;
          due = alu_results_due.pop_front();
          compare_field("result", due.result, out_if.result);
          compare_field("writes_back", 16'(due.writes_back), 16'(out_if.writes_back));
          compare_field("carry", 16'(due.flags.cf), 16'(out_if.carry_out));
          compare_field("parity", 16'(due.flags.pf), 16'(out_if.parity_out));
          compare_field("aux_carry", 16'(due.flags.af), 16'(out_if.aux_carry_out));
          compare_field("zero", 16'(due.flags.zf), 16'(out_if.zero_out));
          compare_field("sign", 16'(due.flags.sf), 16'(out_if.sign_out));
          compare_field("overflow", 16'(due.flags.of), 16'(out_if.overflow_out));
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        take_gap = $urandom_range(0, 10);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.kind      = '0;
    in_if.word_size = 1'b0;
    in_if.operand_a = '0;
    in_if.operand_b = '0;
    out_if.ready    = 1'b0;
    mismatch_count  = 0;
    calm            = 1'b0;

    // Carry chains through ADC and SBB, overflow edges and size limits.
    queue_op(KIND_ADD,  1'b0, 16'h00FF, 16'h0001);
    queue_op(KIND_ADC,  1'b1, 16'h7FFF, 16'h0000);
    queue_op(KIND_SUB,  1'b0, 16'h0000, 16'h0001);
    queue_op(KIND_SBB,  1'b1, 16'h8000, 16'h0000);
    queue_op(KIND_CMP,  1'b0, 16'hFF80, 16'h007F);
    queue_op(KIND_AND,  1'b1, 16'hFFFF, 16'h0000);
    queue_op(KIND_OR,   1'b0, 16'hAB00, 16'hFF80);
    queue_op(KIND_XOR,  1'b0, 16'h00FF, 16'h00FF);
    queue_op(KIND_TEST, 1'b1, 16'h8001, 16'hFFFF);
    queue_op(KIND_INC,  1'b1, 16'h7FFF, 16'h0000);
    queue_op(KIND_DEC,  1'b0, 16'h0080, 16'hFFFF);
    queue_op(KIND_NEG,  1'b0, 16'h0000, 16'h0080);
    queue_op(KIND_NEG,  1'b1, 16'hFFFF, 16'h0000);
    queue_op(KIND_NOT,  1'b1, 16'h1234, 16'h0000);
    // Shifts with a zero count, a count beyond the size and the largest count.
    queue_op(KIND_SHL,  1'b0, 16'h00C3, 16'hFFE0);
    queue_op(KIND_SHL,  1'b0, 16'h00FF, 16'h0009);
    queue_op(KIND_SHL,  1'b1, 16'hFFFF, 16'h001F);
    queue_op(KIND_SHR,  1'b1, 16'h8000, 16'h0001);
    queue_op(KIND_SAR,  1'b0, 16'h0080, 16'h001F);
    queue_op(KIND_ROL,  1'b0, 16'h0081, 16'h0008);
    queue_op(KIND_ROR,  1'b1, 16'h8001, 16'h0011);
    queue_op(KIND_RCL,  1'b0, 16'h00A5, 16'h0009);
    queue_op(KIND_RCR,  1'b1, 16'h0001, 16'h0010);
    queue_op(KIND_UNUSED_LO, 1'b1, 16'hBEEF, 16'hFFFF);
    queue_op(KIND_UNUSED_HI, 1'b0, 16'hBEEF, 16'h0000);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int batch = 0; batch <= RANDOM_BATCHES; batch++) begin
      // Let everything offered so far drain before the next batch goes in.
      while (pending_ops.size() != 0 || in_if.valid) @(negedge clk_i);
      while (alu_results_due.size() != 0) @(negedge clk_i);
      if (batch == RANDOM_BATCHES) break;
      if (batch == RANDOM_BATCHES - 1) calm = 1'b1;
      for (int i = 0; i < BATCH_OPS; i++) begin
        logic [4:0] kind;
        kind = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(20, 31))
                                            : 5'($urandom_range(0, 19));
        queue_op(kind, 1'($urandom), pick_operand(), pick_operand());
      end
    end

    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
